@@ rtl/sm3_pkg.sv @@
// sm3 package: payload structs, constants and round functions
package sm3_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        is_last;
  } sm3_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sm3_out_t;

  localparam logic [31:0] T_LOW   = 32'h79cc4519;
  localparam logic [31:0] T_HIGH  = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [255:0] SM3_IV = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

@@ rtl/sm3_hash_engine.sv @@
// sm3 hash engine top level: word loader, padding, round sequencer, digest output
//
// input channel: one big-endian 32-bit message word per transfer with a valid
// byte count; is_last marks the final word and triggers padding
// output channel: eight digest words per message, word_index 0..7, last_word
// flags the eighth
// each word is written to the block buffer as it is transferred; every
// sixteenth word starts a copy of the message block out of the schedule
// memory into the rolling window, then a compression of 64 rounds, one
// round per cycle
// the last word adds padding words one per cycle, possibly a second block,
// then the digest is shown word by word; in_stall_o stays high from the last
// word until the eighth digest word has been transferred
// the block buffer is a 16-entry synchronous memory with a registered read;
// the round window lives in registers, copied from it before rounds
// reset (asynchronous, active low) loads the initial vector and clears the
// length and position; no clearing pass is needed
// a stalled output holds its word; nothing else proceeds meanwhile
module sm3_hash_engine import sm3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sm3_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sm3_out_t out_data_o
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_COPY = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_PAD = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0]   state_q, state_d;
  logic [31:0]  mem [16];
  logic [31:0]  rd_q;
  logic [3:0]   rd_addr;
  logic         wr_en;
  logic [3:0]   wr_addr;
  logic [31:0]  wr_data;

  logic [31:0]  win_q [16];
  logic [31:0]  r_q [8];
  logic [31:0]  cv_q [8];
  logic [63:0]  len_q;
  logic [3:0]   pos_q;
  logic [6:0]   cnt_q;
  logic         fin_q;      // padding in progress
  logic         len_hi_q;   // pad byte already written
  logic         fits_q;     // length words may go into the current block
  logic         done_q;     // length words have gone into the current block
  logic [2:0]   oidx_q;

  logic in_xfer, out_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != S_LOAD);

  // input word shaping
  logic [2:0]  cnt_eff;
  logic [31:0] mask, in_word;
  always_comb begin
    cnt_eff = (in_data_i.byte_count > 3'd4 || !in_data_i.is_last) ? 3'd4
              : in_data_i.byte_count;
    case (cnt_eff)
      3'd0: mask = 32'h0;
      3'd1: mask = 32'hff000000;
      3'd2: mask = 32'hffff0000;
      3'd3: mask = 32'hffffff00;
      default: mask = 32'hffffffff;
    endcase
    in_word = (in_data_i.message_word & mask)
              | (cnt_eff == 3'd4 ? 32'h0 : ({24'h0, PAD_BYTE} << (6'd24 - {cnt_eff, 3'b0})));
  end

  // pad word for current position
  logic [31:0] pad_word;
  always_comb begin
    if (!len_hi_q) pad_word = {PAD_BYTE, 24'h0};
    else if (fits_q && pos_q == 4'd15) pad_word = len_q[31:0];
    else if (fits_q && pos_q == 4'd14) pad_word = len_q[63:32];
    else pad_word = 32'h0;
  end

  // round logic
  logic [5:0]  j;
  logic [31:0] wj, wj4, tc, a12, ss1, ss2, ff, gg, tt1, tt2, wnext;
  always_comb begin
    j = cnt_q[5:0];
    wj = win_q[j[3:0]];
    wj4 = win_q[j[3:0] + 4'd4];
    tc = rotl((j < 6'd16) ? T_LOW : T_HIGH, j[4:0]);
    a12 = rotl(r_q[0], 5'd12);
    ss1 = rotl(a12 + r_q[4] + tc, 5'd7);
    ss2 = ss1 ^ a12;
    if (j < 6'd16) begin
      ff = r_q[0] ^ r_q[1] ^ r_q[2];
      gg = r_q[4] ^ r_q[5] ^ r_q[6];
    end else begin
      ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
      gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
    end
    tt1 = ff + r_q[3] + ss2 + (wj ^ wj4);
    tt2 = gg + r_q[7] + ss1 + wj;
    wnext = perm1(wj ^ win_q[j[3:0] + 4'd7] ^ rotl(win_q[j[3:0] + 4'd13], 5'd15))
            ^ rotl(win_q[j[3:0] + 4'd3], 5'd7) ^ win_q[j[3:0] + 4'd10];
  end

  always_comb begin
    state_d = state_q;
    wr_en = 1'b0;
    wr_addr = pos_q;
    wr_data = in_word;
    rd_addr = cnt_q[3:0];
    case (state_q)
      S_LOAD: if (in_xfer) wr_en = 1'b1;
      S_PAD: begin
        wr_en = 1'b1;
        wr_data = pad_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      len_q <= '0;
      pos_q <= '0;
      cnt_q <= '0;
      fin_q <= 1'b0;
      len_hi_q <= 1'b0;
      fits_q <= 1'b0;
      oidx_q <= '0;
      for (int i = 0; i < 8; i++) cv_q[i] <= SM3_IV[255 - 32*i -: 32];
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_xfer) begin
            len_q <= len_q + {58'h0, cnt_eff, 3'b0};
            pos_q <= pos_q + 4'd1;
            if (in_data_i.is_last) begin
              fin_q <= 1'b1;
              // a full last word needs its own pad byte word next
              len_hi_q <= (cnt_eff != 3'd4);
              fits_q <= (cnt_eff != 3'd4) && (pos_q <= 4'd13);
            end
            cnt_q <= '0;
            if (pos_q == 4'd15) state_q <= S_COPY;
            else if (in_data_i.is_last) state_q <= S_PAD;
          end
        end
        S_PAD: begin
          // len_hi_q doubles as "pad byte already written"
          pos_q <= pos_q + 4'd1;
          len_hi_q <= 1'b1;
          if (!len_hi_q) fits_q <= (pos_q <= 4'd13);
          if (pos_q == 4'd15) begin
            cnt_q <= '0;
            state_q <= S_COPY;
          end
        end
        S_COPY: begin
          // the memory read is registered, so rd_q holds entry cnt - 1 once cnt is nonzero
          if (cnt_q != 7'd0) win_q[cnt_q[3:0] - 4'd1] <= rd_q;
          if (cnt_q == 7'd16) begin
            for (int i = 0; i < 8; i++) r_q[i] <= cv_q[i];
            cnt_q <= '0;
            state_q <= S_ROUND;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_ROUND: begin
          r_q[3] <= r_q[2];
          r_q[2] <= rotl(r_q[1], 5'd9);
          r_q[1] <= r_q[0];
          r_q[0] <= tt1;
          r_q[7] <= r_q[6];
          r_q[6] <= rotl(r_q[5], 5'd19);
          r_q[5] <= r_q[4];
          r_q[4] <= perm0(tt2);
          win_q[j[3:0]] <= wnext;
          if (cnt_q == 7'd63) begin
            cnt_q <= '0;
            // once the pad byte is in an earlier block the length always fits
            if (fin_q && len_hi_q) fits_q <= 1'b1;
            if (fin_q && done_q) state_q <= S_OUT;
            else if (fin_q) state_q <= S_PAD;
            else state_q <= S_LOAD;
          end else begin
            cnt_q <= cnt_q + 7'd1;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) cv_q[i] <= SM3_IV[255 - 32*i -: 32];
              len_q <= '0;
              pos_q <= '0;
              fin_q <= 1'b0;
              len_hi_q <= 1'b0;
              fits_q <= 1'b0;
              state_q <= S_LOAD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
      // chaining update after the last round
      if (state_q == S_ROUND && cnt_q == 7'd63) begin
        cv_q[0] <= cv_q[0] ^ tt1;
        cv_q[1] <= cv_q[1] ^ r_q[0];
        cv_q[2] <= cv_q[2] ^ rotl(r_q[1], 5'd9);
        cv_q[3] <= cv_q[3] ^ r_q[2];
        cv_q[4] <= cv_q[4] ^ perm0(tt2);
        cv_q[5] <= cv_q[5] ^ r_q[4];
        cv_q[6] <= cv_q[6] ^ rotl(r_q[5], 5'd19);
        cv_q[7] <= cv_q[7] ^ r_q[6];
      end
    end
  end

  // set once the length words have gone into the current block
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else if (state_q == S_OUT) done_q <= 1'b0;
    else if (state_q == S_PAD && pos_q == 4'd15 && len_hi_q && fits_q) done_q <= 1'b1;
  end

  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o.digest_word = cv_q[oidx_q];
  assign out_data_o.word_index = oidx_q;
  assign out_data_o.last_word = (oidx_q == 3'd7);

endmodule

@@ test/testbench.sv @@
// testbench for the sm3 hash engine: directed table and random messages, checked per digest word
`timescale 1ns / 100ps

module testbench;
  import sm3_pkg::*;

  localparam int DIRECTED_ROWS = 12;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  sm3_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  sm3_out_t out_data_o;

  // digest words still to arrive
  sm3_out_t digest_queue[$];
  // typed-in digests; zero where the predictor decides
  logic [31:0] known_digest[$];
  int errors = 0;

  // predictor state
  logic [31:0] hash_state[8];
  logic [31:0] block_words[16];
  logic [63:0] msg_bits;
  int unsigned fill_pos;

  sm3_hash_engine dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] p0_mix(logic [31:0] x);
    return x ^ rol32(x, 9) ^ rol32(x, 17);
  endfunction

  function automatic logic [31:0] p1_mix(logic [31:0] x);
    return x ^ rol32(x, 15) ^ rol32(x, 23);
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = SM3_IV[255 - 32*i -: 32];
    msg_bits = '0;
    fill_pos = 0;
  endtask

  task automatic compress_words();
    logic [31:0] v[8];
    logic [31:0] w[16];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, wn;
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 16; i++) w[i] = block_words[i];
    for (int j = 0; j < 64; j++) begin
      tj = (j < 16) ? T_LOW : T_HIGH;
      a12 = rol32(v[0], 12);
      ss1 = rol32(a12 + v[4] + rol32(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ff + v[3] + ss2 + (w[j%16] ^ w[(j+4)%16]);
      tt2 = gg + v[7] + ss1 + w[j%16];
      v[3] = v[2]; v[2] = rol32(v[1], 9); v[1] = v[0]; v[0] = tt1;
      v[7] = v[6]; v[6] = rol32(v[5], 19); v[5] = v[4]; v[4] = p0_mix(tt2);
      wn = p1_mix(w[j%16] ^ w[(j+7)%16] ^ rol32(w[(j+13)%16], 15))
           ^ rol32(w[(j+3)%16], 7) ^ w[(j+10)%16];
      w[j%16] = wn;
    end
    for (int i = 0; i < 8; i++) hash_state[i] ^= v[i];
  endtask

  task automatic append_word(logic [31:0] w);
    block_words[fill_pos] = w;
    fill_pos = (fill_pos + 1) % 16;
    if (fill_pos == 0) compress_words();
  endtask

  task automatic predict_transfer(sm3_in_t t);
    int unsigned cnt;
    logic [63:0] total;
    logic [31:0] mask;
    sm3_out_t r;
    cnt = t.byte_count;
    if (cnt > 4 || !t.is_last) cnt = 4;
    msg_bits += 64'(cnt * 8);
    if (!t.is_last) begin
      append_word(t.message_word);
      return;
    end
    total = msg_bits;
    if (cnt == 4) begin
      append_word(t.message_word);
      append_word({PAD_BYTE, 24'h0});
    end else begin
      mask = (cnt == 0) ? 32'h0 : (32'hffffffff << (32 - 8*cnt));
      append_word((t.message_word & mask) | (32'(PAD_BYTE) << (24 - 8*cnt)));
    end
    while (fill_pos != 14) append_word('0);
    append_word(total[63:32]);
    append_word(total[31:0]);
    for (int i = 0; i < 8; i++) begin
      r.digest_word = hash_state[i];
      r.word_index = 3'(i);
      r.last_word = (i == 7);
      digest_queue.push_back(r);
    end
    restart_hash();
  endtask

  task automatic send_word(sm3_in_t t);
    in_data_i <= t;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_transfer(t);
  endtask

  // random gap after a burst; within a message valid drops only here
  task automatic maybe_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      @(negedge clk_i);
      return;
    end
    burst = $urandom_range(0, 12);
    @(negedge clk_i);
    if ($urandom_range(0, 2) != 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
  endtask

  // receiver stall pattern
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 60)) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    sm3_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: unexpected digest word, expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        want = digest_queue.pop_front();
        if (out_data_o.digest_word !== want.digest_word) begin
          $display("%0t: digest_word expected %h actual %h", $time,
                   want.digest_word, out_data_o.digest_word);
          errors++;
        end
        if (out_data_o.word_index !== want.word_index) begin
          $display("%0t: word_index expected %0d actual %0d", $time,
                   want.word_index, out_data_o.word_index);
          errors++;
        end
        if (out_data_o.last_word !== want.last_word) begin
          $display("%0t: last_word expected %0d actual %0d", $time,
                   want.last_word, out_data_o.last_word);
          errors++;
        end
        if (known_digest.size() != 0) begin
          if (known_digest[0] != '0 && known_digest[0] !== out_data_o.digest_word) begin
            $display("%0t: known digest expected %h actual %h", $time,
                     known_digest[0], out_data_o.digest_word);
            errors++;
          end
          void'(known_digest.pop_front());
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    sm3_in_t directed[DIRECTED_ROWS];
    logic [31:0] directed_digest[DIRECTED_ROWS][8];
    sm3_in_t t;
    int burst, nwords, sent;
    restart_hash();
    for (int i = 0; i < DIRECTED_ROWS; i++)
      for (int k = 0; k < 8; k++) directed_digest[i][k] = '0;
    // empty message, well-known digest
    directed[0] = '{32'hffffffff, 3'd0, 1'b1};
    directed_digest[0] = '{32'h1ab21d83, 32'h55cfa17f, 32'h8e611948, 32'h31e81a8f,
                           32'h22bec8c7, 32'h28fefb74, 32'h7ed035eb, 32'h5082aa2b};
    // "abc", well-known digest
    directed[1] = '{32'h616263ff, 3'd3, 1'b1};
    directed_digest[1] = '{32'h66c7f0f4, 32'h62eeedd9, 32'hd1f2d46b, 32'hdc10e4e2,
                           32'h4167c487, 32'h5cf2f7a2, 32'h297da02b, 32'h8f4ba8e0};
    directed[2] = '{32'h00000000, 3'd4, 1'b1};
    directed[3] = '{32'hffffffff, 3'd1, 1'b1};
    directed[4] = '{32'hffffffff, 3'd2, 1'b1};
    directed[5] = '{32'hffffffff, 3'd7, 1'b1};   // count above four
    directed[6] = '{32'h12345678, 3'd5, 1'b1};
    directed[7] = '{32'hdeadbeef, 3'd1, 1'b0};   // short word not last: whole word
    directed[8] = '{32'hcafef00d, 3'd6, 1'b0};
    directed[9] = '{32'h00000000, 3'd0, 1'b0};
    directed[10] = '{32'h80808080, 3'd2, 1'b1};
    directed[11] = '{32'hffffffff, 3'd4, 1'b1};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (directed[i].is_last)
        for (int k = 0; k < 8; k++) known_digest.push_back(directed_digest[i][k]);
      send_word(directed[i]);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    // let every directed digest come back before the random part
    while (digest_queue.size() != 0) @(negedge clk_i);

    burst = 0;
    sent = 0;
    while (sent < 380) begin
      // mostly short messages, a few spanning several blocks and boundary lengths
      case ($urandom_range(0, 9))
        0: nwords = $urandom_range(30, 50);
        1: nwords = $urandom_range(13, 17);
        default: nwords = $urandom_range(1, 10);
      endcase
      for (int k = 0; k < nwords; k++) begin
        t.message_word = $urandom;
        t.is_last = (k == nwords - 1);
        t.byte_count = t.is_last ? 3'($urandom_range(0, 7))
                                 : (($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd4);
        send_word(t);
        sent++;
        maybe_gap(burst);
      end
      // hold off until the whole digest is back
      if ($urandom_range(0, 7) == 0) begin
        in_valid_i <= 1'b0;
        while (digest_queue.size() != 0) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (digest_queue.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
